// ===== hdl/hcang_pkg.sv =====
// Package with the shared constants, CORDIC angle table and cell data types.
`default_nettype none
package hcang_pkg;

  localparam int FracBits     = 28;
  localparam int CordicStages = 24;
  localparam int DataW        = 32;
  localparam int ShW          = $clog2(CordicStages);

  // Square root cells: one result bit per cell, root is at most 2^FracBits
  localparam int SqrtCells = FracBits + 1;
  localparam int RemW      = 2 * FracBits + 1;
  localparam int SqIdxW    = $clog2(SqrtCells);

  localparam logic signed [DataW-1:0] Gain    = 32'sd163008219;
  localparam logic signed [DataW-1:0] Pi      = 32'sd843314857;
  localparam logic signed [DataW-1:0] HalfPi  = 32'sd421657428;
  localparam logic signed [DataW-1:0] RedHigh = Pi - HalfPi;
  localparam logic signed [DataW-1:0] One     = 32'sd1 <<< FracBits;

  // atan(2^-i), rounded to FracBits fraction bits
  localparam logic signed [DataW-1:0] AtanTab [CordicStages] = '{
    32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
    32'sd16755422,  32'sd8385879,   32'sd4193963,  32'sd2097109,
    32'sd1048571,   32'sd524287,    32'sd262144,   32'sd131072,
    32'sd65536,     32'sd32768,     32'sd16384,    32'sd8192,
    32'sd4096,      32'sd2048,      32'sd1024,     32'sd512,
    32'sd256,       32'sd128,       32'sd64,       32'sd32
  };

  typedef struct packed {
    logic                    odd;
    logic signed [DataW-1:0] x;
    logic signed [DataW-1:0] y;
    logic signed [DataW-1:0] z;
  } rot_t;

  typedef struct packed {
    logic signed [DataW-1:0] x;
    logic signed [DataW-1:0] y;
    logic signed [DataW-1:0] z;
  } vec_t;

  typedef struct packed {
    logic [RemW-1:0]      rem;
    logic [SqrtCells-1:0] root;
  } sq_t;

endpackage
`default_nettype wire

// ===== hdl/hcang_rot_cell.sv =====
// One rotation-mode CORDIC micro-rotation with its output register.
`default_nettype none
module hcang_rot_cell (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [hcang_pkg::ShW-1:0] shift_i,
  input  hcang_pkg::rot_t          data_i,
  output hcang_pkg::rot_t          data_o
);
  import hcang_pkg::*;

  rot_t data_d, data_q;
  logic signed [DataW-1:0] dx, dy;

  // Rotate toward zero residual angle
  always_comb begin
    dx = data_i.y >>> shift_i;
    dy = data_i.x >>> shift_i;
    data_d.odd = data_i.odd;
    if (data_i.z >= 0) begin
      data_d.x = data_i.x - dx;
      data_d.y = data_i.y + dy;
      data_d.z = data_i.z - AtanTab[shift_i];
    end else begin
      data_d.x = data_i.x + dx;
      data_d.y = data_i.y - dy;
      data_d.z = data_i.z + AtanTab[shift_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) data_q <= data_d;
  end

  assign data_o = data_q;
endmodule
`default_nettype wire

// ===== hdl/hcang_vec_cell.sv =====
// One vectoring-mode CORDIC micro-rotation with its output register.
`default_nettype none
module hcang_vec_cell (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [hcang_pkg::ShW-1:0] shift_i,
  input  hcang_pkg::vec_t          data_i,
  output hcang_pkg::vec_t          data_o
);
  import hcang_pkg::*;

  vec_t data_d, data_q;
  logic signed [DataW-1:0] dx, dy;

  // Rotate the vector toward the x axis, accumulate angle
  always_comb begin
    dx = data_i.y >>> shift_i;
    dy = data_i.x >>> shift_i;
    if (data_i.y > 0) begin
      data_d.x = data_i.x + dx;
      data_d.y = data_i.y - dy;
      data_d.z = data_i.z + AtanTab[shift_i];
    end else begin
      data_d.x = data_i.x - dx;
      data_d.y = data_i.y + dy;
      data_d.z = data_i.z - AtanTab[shift_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) data_q <= data_d;
  end

  assign data_o = data_q;
endmodule
`default_nettype wire

// ===== hdl/hcang_sqrt_cell.sv =====
// One digit of the bit-by-bit square root recurrence with its output register.
`default_nettype none
module hcang_sqrt_cell (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [hcang_pkg::SqIdxW-1:0] bit_i,
  input  hcang_pkg::sq_t              data_i,
  output hcang_pkg::sq_t              data_o
);
  import hcang_pkg::*;

  sq_t data_d, data_q;
  logic [RemW:0] trial;

  // Try setting this root bit: remainder must cover 2*root*2^j + 4^j
  always_comb begin
    trial = ((RemW+1)'(data_i.root) << (bit_i + 1'b1))
          + ((RemW+1)'(1) << {bit_i, 1'b0});
    data_d = data_i;
    if ({1'b0, data_i.rem} >= trial) begin
      data_d.rem  = data_i.rem - trial[RemW-1:0];
      data_d.root = data_i.root | (SqrtCells'(1) << bit_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) data_q <= data_d;
  end

  assign data_o = data_q;
endmodule
`default_nettype wire

// ===== hdl/haversine_central_angle.sv =====
// Top level: pipelined haversine central angle between two points.
`default_nettype none
// Takes two points as longitude (signed Q3.28) and latitude (signed Q2.28) in radians
// and returns the great-circle central angle in unsigned Q2.28 radians. The datapath
// is a fixed pipeline of 85 register stages:
// - an input stage that forms the half differences;
// - a range-reduction stage;
// - four lanes of 24 rotation CORDIC cells for the sines and cosines;
// - five stages for the sign fix, the two registered multiplies, the haversine
//   sum, and the clamp with 1-h;
// - two lanes of 29 square-root digit cells;
// - 24 vectoring CORDIC cells for atan2;
// - the output register.
// A new transaction is accepted every cycle unless the pipeline is stalled.
// out_valid_o comes from the last bit of a valid shift register that advances with the
// datapath, so it rises as the output register takes the result. The whole pipeline
// stalls together only while the output register holds a result that is not taken.
module haversine_central_angle (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [30:0] src_longitude_i,
  input  logic signed [29:0] src_latitude_i,
  input  logic signed [30:0] dst_longitude_i,
  input  logic signed [29:0] dst_latitude_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [29:0]        central_angle_o
);
  import hcang_pkg::*;

  localparam int Depth = 2 + CordicStages + 5 + SqrtCells + CordicStages + 1;
  localparam int Lanes = 4;

  logic             adv;
  logic [Depth-1:0] vld_q;

  // Front stage: half differences and raw latitudes
  logic signed [DataW-1:0] ang_d [Lanes];
  logic signed [DataW-1:0] ang_q [Lanes];
  rot_t                    red_d [Lanes];
  rot_t                    red_q [Lanes];
  rot_t                    rot_w [Lanes][CordicStages+1];

  logic signed [DataW-1:0] sl_q, sg_q, c1_q, c2_q;
  logic signed [2*DataW-1:0] m1_q, m2_q, m3_q, m4_q;
  logic signed [DataW-1:0] p1_q, h_q;
  logic [FracBits:0]       hc_d, hc_q, omh_q;

  sq_t  sqa_w [SqrtCells+1];
  sq_t  sqb_w [SqrtCells+1];
  vec_t vec_w [CordicStages+1];

  logic signed [DataW:0] ang2;
  logic [29:0]           out_d, out_q;

  // Advance the whole pipeline unless a result waits at the output
  assign adv        = !vld_q[Depth-1] || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end

  always_comb begin
    ang_d[0] = (DataW'(dst_latitude_i) - DataW'(src_latitude_i)) >>> 1;
    ang_d[1] = (DataW'(dst_longitude_i) - DataW'(src_longitude_i)) >>> 1;
    ang_d[2] = DataW'(src_latitude_i);
    ang_d[3] = DataW'(dst_latitude_i);
  end

  // Reduce each angle to [-pi/2, pi/2) and mark an odd multiple of pi
  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      red_d[l].x   = Gain;
      red_d[l].y   = '0;
      red_d[l].odd = 1'b0;
      red_d[l].z   = ang_q[l];
      if (ang_q[l] >= RedHigh) begin
        red_d[l].z   = ang_q[l] - Pi;
        red_d[l].odd = 1'b1;
      end else if (ang_q[l] < -HalfPi) begin
        red_d[l].z   = ang_q[l] + Pi;
        red_d[l].odd = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ang_q <= ang_d;
      red_q <= red_d;
    end
  end

  // Sine/cosine lanes
  for (genvar l = 0; l < Lanes; l++) begin : g_lane
    assign rot_w[l][0] = red_q[l];
    for (genvar k = 0; k < CordicStages; k++) begin : g_rot
      hcang_rot_cell u_cell (
        .clk_i  (clk_i),
        .en_i   (adv),
        .shift_i(ShW'(k)),
        .data_i (rot_w[l][k]),
        .data_o (rot_w[l][k+1])
      );
    end
  end

  // Sign fix, products and haversine sum
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sl_q  <= rot_w[0][CordicStages].odd ? -rot_w[0][CordicStages].y
                                          :  rot_w[0][CordicStages].y;
      sg_q  <= rot_w[1][CordicStages].odd ? -rot_w[1][CordicStages].y
                                          :  rot_w[1][CordicStages].y;
      c1_q  <= rot_w[2][CordicStages].odd ? -rot_w[2][CordicStages].x
                                          :  rot_w[2][CordicStages].x;
      c2_q  <= rot_w[3][CordicStages].odd ? -rot_w[3][CordicStages].x
                                          :  rot_w[3][CordicStages].x;
      m1_q  <= sl_q * sl_q;
      m2_q  <= c1_q * c2_q;
      m3_q  <= sg_q * sg_q;
      p1_q  <= DataW'(m1_q >>> FracBits);
      m4_q  <= DataW'(m2_q >>> FracBits) * DataW'(m3_q >>> FracBits);
      h_q   <= p1_q + DataW'(m4_q >>> FracBits);
      hc_q  <= hc_d;
      omh_q <= (FracBits+1)'(One) - hc_d;
    end
  end

  // Clamp h to [0, 1]
  always_comb begin
    if (h_q < 0) begin
      hc_d = '0;
    end else if (h_q > One) begin
      hc_d = (FracBits+1)'(One);
    end else begin
      hc_d = (FracBits+1)'(h_q);
    end
  end

  // Square roots of h and 1-h, most significant bit first
  assign sqa_w[0].rem  = {hc_q, FracBits'(0)};
  assign sqa_w[0].root = '0;
  assign sqb_w[0].rem  = {omh_q, FracBits'(0)};
  assign sqb_w[0].root = '0;

  for (genvar k = 0; k < SqrtCells; k++) begin : g_sqrt
    hcang_sqrt_cell u_sqa (
      .clk_i (clk_i),
      .en_i  (adv),
      .bit_i (SqIdxW'(SqrtCells - 1 - k)),
      .data_i(sqa_w[k]),
      .data_o(sqa_w[k+1])
    );
    hcang_sqrt_cell u_sqb (
      .clk_i (clk_i),
      .en_i  (adv),
      .bit_i (SqIdxW'(SqrtCells - 1 - k)),
      .data_i(sqb_w[k]),
      .data_o(sqb_w[k+1])
    );
  end

  // atan2(sqrt(h), sqrt(1-h))
  assign vec_w[0].x = DataW'(sqb_w[SqrtCells].root);
  assign vec_w[0].y = DataW'(sqa_w[SqrtCells].root);
  assign vec_w[0].z = '0;

  for (genvar k = 0; k < CordicStages; k++) begin : g_vec
    hcang_vec_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .shift_i(ShW'(k)),
      .data_i (vec_w[k]),
      .data_o (vec_w[k+1])
    );
  end

  // Double the angle and clamp to [0, pi]
  always_comb begin
    ang2 = (DataW+1)'(vec_w[CordicStages].z) <<< 1;
    if (ang2 < 0) begin
      out_d = '0;
    end else if (ang2 > (DataW+1)'(Pi)) begin
      out_d = 30'(Pi);
    end else begin
      out_d = 30'(ang2);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_q <= out_d;
  end

  assign out_valid_o     = vld_q[Depth-1];
  assign central_angle_o = out_q;

endmodule
`default_nettype wire
